### hw/rtl/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int STAMP_W  = 32;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // One result transaction.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] read_handle;
    logic                release_valid;
    logic [HANDLE_W-1:0] release_handle;
    logic                last;
  } res_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;
    logic valid;
  } scan_ctl_t;

  // Findings of the scan unit.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] hit_handle;
    logic [HANDLE_W-1:0] lru_handle;
  } scan_res_t;

endpackage
`default_nettype wire

### hw/rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: memory, scan unit, sequencer, output register.
//
// Input channel (in_valid/in_ready) carries one request: in_op selects get,
// put, clear or no-op, in_key is the lookup tag (low KEY_BITS bits used) and
// in_handle is the value for a put. Result channel (out_valid/out_ready)
// carries hit, read_handle, release_valid, release_handle and last.
// Every request yields one result, except a clear of a non-empty table,
// which yields one release per stored entry with last on the final one.
// Requests are handled one at a time. A get or a non-null put with at least
// one stored entry sweeps the entry memory one read per cycle and then
// reaches the output register from the final step; the next request can be
// taken once the sequencer is back in idle. Null puts, no-ops and requests
// on an empty table go straight to the final step. A clear reads each
// stored entry and then emits it as a release.
// A waiting result sits in the output register while the next request is
// taken; when the receiver stalls, the sequencer holds its final step until
// the output register frees up, and no result is lost.
// Reset empties the table and clears the use counter; no clearing pass.
`default_nettype none
module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_op,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [HANDLE_W-1:0] in_handle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_hit,
  output logic      [HANDLE_W-1:0] out_read_handle,
  output logic                     out_release_valid,
  output logic      [HANDLE_W-1:0] out_release_handle,
  output logic                     out_last
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int WORD_W = KEY_BITS + HANDLE_W + STAMP_W;

  logic                rd_en, wr_en, push, slot_free;
  logic [IDX_W-1:0]    rd_addr, wr_addr, scan_idx, hit_idx, lru_idx;
  logic [WORD_W-1:0]   rd_data, wr_data;
  logic [KEY_BITS-1:0] scan_key;
  scan_ctl_t           scan_ctl;
  scan_res_t           scan_res;
  res_t                res;
  res_t                out_r;
  logic                out_valid_r, out_valid_nxt;

  lkvc_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lkvc_scan #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .idx     (scan_idx),
    .word    (rd_data),
    .key     (scan_key),
    .res     (scan_res),
    .hit_idx (hit_idx),
    .lru_idx (lru_idx)
  );

  lkvc_ctrl #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_key    (in_key),
    .in_handle (in_handle),
    .slot_free (slot_free),
    .push      (push),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .scan_ctl  (scan_ctl),
    .scan_idx  (scan_idx),
    .scan_key  (scan_key),
    .scan_res  (scan_res),
    .hit_idx   (hit_idx),
    .lru_idx   (lru_idx)
  );

  // Output register: free when empty or being taken this cycle.
  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid_nxt = push || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_r.hit;
  assign out_read_handle    = out_r.read_handle;
  assign out_release_valid  = out_r.release_valid;
  assign out_release_handle = out_r.release_handle;
  assign out_last           = out_r.last;

endmodule
`default_nettype wire

### hw/rtl/lkvc_mem.sv
// Entry memory with one write port and one registered read port.
`default_nettype none
module lkvc_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 128,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lkvc_scan.sv
// Scan unit: finds the first key match and the oldest stamp over a sweep.
`default_nettype none
module lkvc_scan
  import lkvc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  parameter int IDX_W    = $clog2(ENTRIES),
  parameter int WORD_W   = KEY_BITS + HANDLE_W + STAMP_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire scan_ctl_t           ctl,
  input  wire logic [IDX_W-1:0]    idx,
  input  wire logic [WORD_W-1:0]   word,
  input  wire logic [KEY_BITS-1:0] key,
  output scan_res_t                res,
  output logic      [IDX_W-1:0]    hit_idx,
  output logic      [IDX_W-1:0]    lru_idx
);

  logic                hit_r, first_r;
  logic [HANDLE_W-1:0] hit_handle_r, lru_handle_r;
  logic [STAMP_W-1:0]  min_r;
  logic [IDX_W-1:0]    hit_idx_r, lru_idx_r;

  logic [KEY_BITS-1:0] w_key;
  logic [HANDLE_W-1:0] w_handle;
  logic [STAMP_W-1:0]  w_stamp;

  assign w_key    = word[WORD_W-1 -: KEY_BITS];
  assign w_handle = word[STAMP_W +: HANDLE_W];
  assign w_stamp  = word[STAMP_W-1:0];

  // Match and minimum tracking flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      first_r <= 1'b1;
    end else if (ctl.start) begin
      hit_r   <= 1'b0;
      first_r <= 1'b1;
    end else if (ctl.valid) begin
      first_r <= 1'b0;
      if (!hit_r && w_key == key) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Captured payload of the match and of the oldest entry; ties keep the lower index.
  always_ff @(posedge clk) begin
    if (ctl.valid && !ctl.start) begin
      if (!hit_r && w_key == key) begin
        hit_idx_r    <= idx;
        hit_handle_r <= w_handle;
      end
      if (first_r || w_stamp < min_r) begin
        min_r        <= w_stamp;
        lru_idx_r    <= idx;
        lru_handle_r <= w_handle;
      end
    end
  end

  assign res.hit        = hit_r;
  assign res.hit_handle = hit_handle_r;
  assign res.lru_handle = lru_handle_r;
  assign hit_idx        = hit_idx_r;
  assign lru_idx        = lru_idx_r;

endmodule
`default_nettype wire

### hw/rtl/lkvc_ctrl.sv
// Sequencer: accepts requests, sweeps the entry memory, writes back and emits clear releases.
`default_nettype none
module lkvc_ctrl
  import lkvc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  parameter int IDX_W    = $clog2(ENTRIES),
  parameter int CNT_W    = $clog2(ENTRIES + 1),
  parameter int WORD_W   = KEY_BITS + HANDLE_W + STAMP_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_op,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic                slot_free,
  output logic                     push,
  output res_t                     res,
  output logic                     rd_en,
  output logic      [IDX_W-1:0]    rd_addr,
  input  wire logic [WORD_W-1:0]   rd_data,
  output logic                     wr_en,
  output logic      [IDX_W-1:0]    wr_addr,
  output logic      [WORD_W-1:0]   wr_data,
  output scan_ctl_t                scan_ctl,
  output logic      [IDX_W-1:0]    scan_idx,
  output logic      [KEY_BITS-1:0] scan_key,
  input  wire scan_res_t           scan_res,
  input  wire logic [IDX_W-1:0]    hit_idx,
  input  wire logic [IDX_W-1:0]    lru_idx
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FIN    = 5'b00100,
    S_CLR_RD = 5'b01000,
    S_CLR_EM = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic [STAMP_W-1:0]  ctr_r, ctr_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [STAMP_W-1:0]  ctr_inc;
  logic [HANDLE_W-1:0] rd_handle;
  logic                clr_last;

  assign ctr_inc   = ctr_r + STAMP_W'(1);
  assign rd_handle = rd_data[STAMP_W +: HANDLE_W];
  assign clr_last  = (issue_r + CNT_W'(1)) == count_r;
  assign in_ready  = (state_r == S_IDLE);
  assign scan_key  = key_r;
  assign scan_idx  = cmp_idx_r;

  // Next-state and datapath decisions.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    handle_nxt  = handle_r;
    count_nxt   = count_r;
    issue_nxt   = issue_r;
    ctr_nxt     = ctr_r;
    pend_nxt    = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    push        = 1'b0;
    res         = '0;
    res.last    = 1'b1;
    rd_en       = 1'b0;
    rd_addr     = issue_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = hit_idx;
    wr_data     = {key_r, handle_r, ctr_inc};
    scan_ctl    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = op_t'(in_op);
          key_nxt        = in_key[KEY_BITS-1:0];
          handle_nxt     = in_handle;
          issue_nxt      = '0;
          scan_ctl.start = 1'b1;
          if ((op_t'(in_op) == OP_GET ||
               (op_t'(in_op) == OP_PUT && in_handle != '0)) && count_r != '0) begin
            state_nxt = S_SCAN;
          end else if (op_t'(in_op) == OP_CLEAR && count_r != '0) begin
            state_nxt = S_CLR_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      // One read per cycle; each entry is compared the cycle after its read.
      S_SCAN: begin
        scan_ctl.valid = pend_r;
        if (issue_r < count_r) begin
          rd_en       = 1'b1;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Produce the single result and, for a get hit or a non-null put, write the entry.
      S_FIN: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_GET: begin
              ctr_nxt = ctr_inc;
              if (scan_res.hit) begin
                res.hit         = 1'b1;
                res.read_handle = scan_res.hit_handle;
                wr_en           = 1'b1;
                wr_addr         = hit_idx;
                wr_data         = {key_r, scan_res.hit_handle, ctr_inc};
              end
            end
            OP_PUT: begin
              if (handle_r != '0) begin
                ctr_nxt = ctr_inc;
                wr_en   = 1'b1;
                if (scan_res.hit) begin
                  res.hit = 1'b1;
                  wr_addr = hit_idx;
                  if (scan_res.hit_handle != handle_r) begin
                    res.release_valid  = 1'b1;
                    res.release_handle = scan_res.hit_handle;
                  end
                end else if (count_r < CNT_W'(ENTRIES)) begin
                  wr_addr   = count_r[IDX_W-1:0];
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  wr_addr = lru_idx;
                  if (scan_res.lru_handle != '0) begin
                    res.release_valid  = 1'b1;
                    res.release_handle = scan_res.lru_handle;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CLR_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_CLR_EM;
      end

      // Emit one release per stored entry.
      S_CLR_EM: begin
        if (slot_free) begin
          push               = 1'b1;
          res.release_valid  = 1'b1;
          res.release_handle = rd_handle;
          res.last           = clr_last;
          if (clr_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            issue_nxt = issue_r + CNT_W'(1);
            state_nxt = S_CLR_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ctr_r   <= '0;
      pend_r  <= 1'b0;
      issue_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ctr_r   <= ctr_nxt;
      pend_r  <= pend_nxt;
      issue_r <= issue_nxt;
    end
  end

  // Request payload registers.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    handle_r  <= handle_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

endmodule
`default_nettype wire
